// ===== sv/pbx_pkg.sv =====
// shared types, constants and the varint step function for the nested bytes field extractor
// no dependencies
package pbx_pkg;

  localparam int MAX_MSG_BYTES = 65535;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE_FIELD  = 2'd0,
    REG_WANTED_TYPE = 2'd1,
    REG_FRAME_FIELD = 2'd2,
    REG_DATA_FIELD  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_VAR  = 3'd1,
    PH_LEN  = 3'd2,
    PH_SKIP = 3'd3,
    PH_IDLE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_FOUND  = 2'd1,
    RES_FAILED = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    VS_MORE = 2'd0,
    VS_DONE = 2'd1,
    VS_ERR  = 2'd2
  } vstat_t;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;
  localparam logic [3:0] VARINT_MAX  = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } out_t;

  typedef struct packed {
    logic [28:0] type_field_number;
    logic [31:0] wanted_type_value;
    logic [28:0] frame_field_number;
    logic [28:0] data_field_number;
  } cfg_t;

  typedef struct packed {
    vstat_t      stat;
    logic [63:0] acc;
    logic [3:0]  cnt;
  } vstep_t;

  function automatic vstep_t varint_take(logic [63:0] acc, logic [3:0] cnt, logic [7:0] b);
    vstep_t     r;
    logic [5:0] sh;
    r.acc  = acc;
    r.cnt  = cnt;
    r.stat = VS_ERR;
    sh     = 6'(7 * int'(cnt));
    if (cnt < VARINT_MAX) begin
      r.acc = acc | ({57'b0, b[6:0]} << sh);
      r.cnt = cnt + 4'd1;
      if (!b[7]) begin
        r.stat = VS_DONE;
      end else if (r.cnt >= VARINT_MAX) begin
        r.stat = VS_ERR;
      end else begin
        r.stat = VS_MORE;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/pbx_scan.sv =====
// two-level wire format scanner: parser state registers and the per-word update logic
// depends on pbx_pkg
module pbx_scan #(
  parameter int MAX_MESSAGE_BYTES = pbx_pkg::MAX_MSG_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc_i,
  input  pbx_pkg::in_t  word_i,
  input  pbx_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output pbx_pkg::out_t res_o
);

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [PW-1:0] MAXP = PW'(MAX_MESSAGE_BYTES);

  logic [PW-1:0]    pos_r, pos_nxt;
  logic             fail_r, fail_nxt;
  pbx_pkg::phase_t  oph_r, oph_nxt;
  logic [63:0]      oacc_r, oacc_nxt;
  logic [3:0]       ocnt_r, ocnt_nxt;
  logic [31:0]      ofield_r, ofield_nxt;
  logic [2:0]       owire_r, owire_nxt;
  logic [PW-1:0]    orem_r, orem_nxt;
  logic             tmatch_r, tmatch_nxt;
  logic             subp_r, subp_nxt;
  logic [PW-1:0]    subend_r, subend_nxt;
  logic             insub_r, insub_nxt;
  pbx_pkg::phase_t  iph_r, iph_nxt;
  logic [63:0]      iacc_r, iacc_nxt;
  logic [3:0]       icnt_r, icnt_nxt;
  logic [31:0]      ifield_r, ifield_nxt;
  logic [PW-1:0]    irem_r, irem_nxt;
  pbx_pkg::res_t    ires_r, ires_nxt;
  logic [15:0]      foff_r, foff_nxt;
  logic [15:0]      flen_r, flen_nxt;
  logic             ok;

  always_comb begin
    pbx_pkg::vstep_t vs;
    pbx_pkg::vstep_t ws;
    logic [63:0]     n;
    logic [PW-1:0]   room;
    logic [PW:0]     sum;
    logic            do_skip;
    logic            is_sub;
    pos_nxt    = pos_r;
    fail_nxt   = fail_r;
    oph_nxt    = oph_r;
    oacc_nxt   = oacc_r;
    ocnt_nxt   = ocnt_r;
    ofield_nxt = ofield_r;
    owire_nxt  = owire_r;
    orem_nxt   = orem_r;
    tmatch_nxt = tmatch_r;
    subp_nxt   = subp_r;
    subend_nxt = subend_r;
    insub_nxt  = insub_r;
    iph_nxt    = iph_r;
    iacc_nxt   = iacc_r;
    icnt_nxt   = icnt_r;
    ifield_nxt = ifield_r;
    irem_nxt   = irem_r;
    ires_nxt   = ires_r;
    foff_nxt   = foff_r;
    flen_nxt   = flen_r;
    vs         = pbx_pkg::varint_take(oacc_r, ocnt_r, word_i.data_byte);
    ws         = pbx_pkg::varint_take(iacc_r, icnt_r, word_i.data_byte);
    n          = '0;
    do_skip    = 1'b0;
    is_sub     = 1'b0;
    sum        = '0;
    room       = '0;

    if (pos_r >= MAXP) begin
      fail_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + PW'(1);
    end
    room = (subend_r >= pos_nxt) ? subend_r - pos_nxt : '0;

    if (!fail_nxt) begin
      if (oph_r == pbx_pkg::PH_SKIP) begin
        // inner scanner sees the sub-message bytes
        if (insub_r) begin
          if (iph_r == pbx_pkg::PH_SKIP) begin
            irem_nxt = irem_r - PW'(1);
            if (irem_nxt == '0) iph_nxt = pbx_pkg::PH_TAG;
          end else if (iph_r != pbx_pkg::PH_IDLE) begin
            iacc_nxt = ws.acc;
            icnt_nxt = ws.cnt;
            if (ws.stat == pbx_pkg::VS_ERR) begin
              ires_nxt = pbx_pkg::RES_FAILED;
              iph_nxt  = pbx_pkg::PH_IDLE;
            end else if (ws.stat == pbx_pkg::VS_DONE) begin
              iacc_nxt = '0;
              icnt_nxt = '0;
              n        = '0;
              if (iph_r == pbx_pkg::PH_VAR) begin
                iph_nxt = pbx_pkg::PH_TAG;
              end else if (iph_r == pbx_pkg::PH_LEN) begin
                n = ws.acc;
                if (ifield_r == {3'b0, cfg_i.data_field_number}) begin
                  if (n == '0 || n > 64'(room)) begin
                    ires_nxt = pbx_pkg::RES_FAILED;
                    iph_nxt  = pbx_pkg::PH_IDLE;
                  end else begin
                    foff_nxt = 16'(pos_nxt);
                    flen_nxt = n[15:0];
                    ires_nxt = pbx_pkg::RES_FOUND;
                    iph_nxt  = pbx_pkg::PH_IDLE;
                  end
                end else begin
                  do_skip = 1'b1;
                end
              end else begin
                ifield_nxt = ws.acc[34:3];
                unique case (ws.acc[2:0])
                  pbx_pkg::WIRE_VARINT: iph_nxt = pbx_pkg::PH_VAR;
                  pbx_pkg::WIRE_FIX64: begin
                    n       = 64'd8;
                    do_skip = 1'b1;
                  end
                  pbx_pkg::WIRE_LEN:    iph_nxt = pbx_pkg::PH_LEN;
                  pbx_pkg::WIRE_FIX32: begin
                    n       = 64'd4;
                    do_skip = 1'b1;
                  end
                  default: begin
                    ires_nxt = pbx_pkg::RES_FAILED;
                    iph_nxt  = pbx_pkg::PH_IDLE;
                  end
                endcase
              end
              if (do_skip) begin
                if (n > 64'(room)) begin
                  ires_nxt = pbx_pkg::RES_FAILED;
                  iph_nxt  = pbx_pkg::PH_IDLE;
                end else if (n == '0) begin
                  iph_nxt = pbx_pkg::PH_TAG;
                end else begin
                  irem_nxt = n[PW-1:0];
                  iph_nxt  = pbx_pkg::PH_SKIP;
                end
              end
            end
          end
        end
        orem_nxt = orem_r - PW'(1);
        if (orem_nxt == '0) begin
          if (insub_r) iph_nxt = pbx_pkg::PH_IDLE;
          insub_nxt = 1'b0;
          oph_nxt   = pbx_pkg::PH_TAG;
        end
      end else begin
        oacc_nxt = vs.acc;
        ocnt_nxt = vs.cnt;
        if (vs.stat == pbx_pkg::VS_ERR) begin
          fail_nxt = 1'b1;
        end else if (vs.stat == pbx_pkg::VS_DONE) begin
          oacc_nxt = '0;
          ocnt_nxt = '0;
          if (oph_r == pbx_pkg::PH_VAR) begin
            if (ofield_r == {3'b0, cfg_i.type_field_number} && owire_r == pbx_pkg::WIRE_VARINT)
              tmatch_nxt = (vs.acc == {32'b0, cfg_i.wanted_type_value});
            oph_nxt = pbx_pkg::PH_TAG;
          end else if (oph_r == pbx_pkg::PH_LEN) begin
            n       = vs.acc;
            is_sub  = (ofield_r == {3'b0, cfg_i.frame_field_number});
            do_skip = 1'b1;
          end else begin
            ofield_nxt = vs.acc[34:3];
            owire_nxt  = vs.acc[2:0];
            unique case (vs.acc[2:0])
              pbx_pkg::WIRE_VARINT: oph_nxt = pbx_pkg::PH_VAR;
              pbx_pkg::WIRE_FIX64: begin
                n       = 64'd8;
                do_skip = 1'b1;
              end
              pbx_pkg::WIRE_LEN:    oph_nxt = pbx_pkg::PH_LEN;
              pbx_pkg::WIRE_FIX32: begin
                n       = 64'd4;
                do_skip = 1'b1;
              end
              default:              fail_nxt = 1'b1;
            endcase
          end
          if (do_skip) begin
            sum = {1'b0, pos_nxt} + {1'b0, n[PW-1:0]};
            if (n > 64'(MAXP) || sum > {1'b0, MAXP}) begin
              fail_nxt = 1'b1;
            end else begin
              if (is_sub) begin
                subp_nxt   = 1'b1;
                subend_nxt = sum[PW-1:0];
                iacc_nxt   = '0;
                icnt_nxt   = '0;
                ifield_nxt = '0;
                irem_nxt   = '0;
                ires_nxt   = pbx_pkg::RES_NONE;
                iph_nxt    = (n == '0) ? pbx_pkg::PH_IDLE : pbx_pkg::PH_TAG;
              end
              insub_nxt = is_sub;
              if (n == '0) begin
                oph_nxt = pbx_pkg::PH_TAG;
              end else begin
                orem_nxt = n[PW-1:0];
                oph_nxt  = pbx_pkg::PH_SKIP;
              end
            end
          end
        end
      end
    end

    ok = !fail_nxt && pos_nxt >= PW'(2) && oph_nxt == pbx_pkg::PH_TAG && ocnt_nxt == '0 &&
         tmatch_nxt && subp_nxt && ires_nxt == pbx_pkg::RES_FOUND;
  end

  assign res_valid_o          = acc_i && word_i.last_byte;
  assign res_o.found          = ok;
  assign res_o.payload_offset = ok ? foff_nxt : 16'd0;
  assign res_o.payload_length = ok ? flen_nxt : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || (acc_i && word_i.last_byte)) begin
      pos_r    <= '0;
      fail_r   <= 1'b0;
      oph_r    <= pbx_pkg::PH_TAG;
      oacc_r   <= '0;
      ocnt_r   <= '0;
      ofield_r <= '0;
      owire_r  <= '0;
      orem_r   <= '0;
      tmatch_r <= 1'b0;
      subp_r   <= 1'b0;
      subend_r <= '0;
      insub_r  <= 1'b0;
      iph_r    <= pbx_pkg::PH_IDLE;
      iacc_r   <= '0;
      icnt_r   <= '0;
      ifield_r <= '0;
      irem_r   <= '0;
      ires_r   <= pbx_pkg::RES_NONE;
      foff_r   <= '0;
      flen_r   <= '0;
    end else if (acc_i) begin
      pos_r    <= pos_nxt;
      fail_r   <= fail_nxt;
      oph_r    <= oph_nxt;
      oacc_r   <= oacc_nxt;
      ocnt_r   <= ocnt_nxt;
      ofield_r <= ofield_nxt;
      owire_r  <= owire_nxt;
      orem_r   <= orem_nxt;
      tmatch_r <= tmatch_nxt;
      subp_r   <= subp_nxt;
      subend_r <= subend_nxt;
      insub_r  <= insub_nxt;
      iph_r    <= iph_nxt;
      iacc_r   <= iacc_nxt;
      icnt_r   <= icnt_nxt;
      ifield_r <= ifield_nxt;
      irem_r   <= irem_nxt;
      ires_r   <= ires_nxt;
      foff_r   <= foff_nxt;
      flen_r   <= flen_nxt;
    end
  end

endmodule

// ===== sv/protobuf_nested_bytes_field_extractor.sv =====
// Takes one message byte per cycle and reports, with the last byte, whether the configured
// nested bytes field was found, plus its offset and length. The result appears in the output
// register the cycle after the last byte is taken, and a new byte is taken in every cycle in
// which that register is empty or being emptied.
// top level: configuration registers, scanner and result register; depends on pbx_pkg, pbx_scan
module protobuf_nested_bytes_field_extractor #(
  parameter int MAX_MESSAGE_BYTES = pbx_pkg::MAX_MSG_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pbx_pkg::in_t                     in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pbx_pkg::out_t                    out_word,
  input  logic                             cfg_we,
  input  logic [pbx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbx_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pbx_pkg::cfg_t cfg_r;
  logic          out_valid_r;
  pbx_pkg::out_t out_word_r;
  logic          acc;
  logic          res_valid;
  pbx_pkg::out_t res;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_field_number  <= 29'd10;
      cfg_r.wanted_type_value  <= 32'd40;
      cfg_r.frame_field_number <= 29'd80;
      cfg_r.data_field_number  <= 29'd5;
    end else if (cfg_we) begin
      unique case (pbx_pkg::reg_idx_t'(cfg_index))
        pbx_pkg::REG_TYPE_FIELD:  cfg_r.type_field_number  <= cfg_data[28:0];
        pbx_pkg::REG_WANTED_TYPE: cfg_r.wanted_type_value  <= cfg_data;
        pbx_pkg::REG_FRAME_FIELD: cfg_r.frame_field_number <= cfg_data[28:0];
        pbx_pkg::REG_DATA_FIELD:  cfg_r.data_field_number  <= cfg_data[28:0];
        default: ;
      endcase
    end
  end

  pbx_scan #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (acc),
    .word_i     (in_word),
    .cfg_i      (cfg_r),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res;
    end
  end

endmodule

// ===== sv/pbx_checker.sv =====
// port-level checks for the nested bytes field extractor, bound to the top level
// depends on pbx_pkg and protobuf_nested_bytes_field_extractor
module pbx_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input pbx_pkg::in_t  in_word,
  input logic          out_valid,
  input logic          out_ready,
  input pbx_pkg::out_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_word.last_byte))
    else $error("result without a last byte");

  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.found |-> out_word.payload_offset == 16'd0 &&
                                     out_word.payload_length == 16'd0)
    else $error("non-zero fields on a miss");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.found |-> out_word.payload_length != 16'd0)
    else $error("empty payload reported as found");

endmodule

bind protobuf_nested_bytes_field_extractor pbx_checker u_pbx_checker (.*);
